// ===== hw/rtl/pbgr_pkg.sv =====
// Shared types and constants for the proportional bitmap glyph renderer.
package pbgr_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int FONT_BYTES  = 4096;
    localparam int MAX_HEIGHT  = 32;

    localparam int GLYPH_AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int FONT_AW  = $clog2(FONT_BYTES);
    localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [8:0]  GLYPH_LIMIT  = 9'(GLYPH_COUNT);
    localparam logic [16:0] FONT_LIMIT   = 17'(FONT_BYTES);
    localparam logic [6:0]  HEIGHT_LIMIT = 7'(MAX_HEIGHT);

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        ACT_GLYPH = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_BEGIN = 2'd2,
        ACT_DRAW  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_FONT   = 2'd1,
        STS_BAD_GLYPH = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_FONT_VALID   = 3'd0,
        REG_FIRST_CHAR   = 3'd1,
        REG_GLYPH_HEIGHT = 3'd2,
        REG_ROW_PITCH    = 3'd3,
        REG_CLIP_LEFT    = 3'd4,
        REG_CLIP_TOP     = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LOOKUP,
        SEQ_SETUP,
        SEQ_ROWS,
        SEQ_ERROR
    } seq_state_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  char_code;
        logic [7:0]  glyph_width;
        logic [11:0] glyph_offset;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [11:0] start_x;
        logic [10:0] start_y;
        logic [7:0]  text_colour;
    } pbgr_in_t;

    typedef struct packed {
        status_t     status;
        logic [23:0] row_address;
        logic [7:0]  pixel_mask;
        logic [7:0]  pixel_colour;
        logic [15:0] pen_x;
        logic        last;
    } pbgr_out_t;

    typedef struct packed {
        logic        font_valid;
        logic [7:0]  first_char;
        logic [5:0]  glyph_height;
        logic [11:0] row_pitch;
        logic [11:0] clip_left;
        logic [10:0] clip_top;
    } pbgr_cfg_t;

    typedef struct packed {
        logic [7:0]  width;
        logic [11:0] offset;
    } glyph_entry_t;

endpackage

// ===== hw/rtl/pbgr_cfg.sv =====
// APB configuration registers of the glyph renderer.
module pbgr_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbgr_pkg::PADDR_W-1:0]  paddr,
    input  logic [pbgr_pkg::PDATA_W-1:0]  pwdata,
    output logic [pbgr_pkg::PDATA_W-1:0]  prdata,
    output pbgr_pkg::pbgr_cfg_t           cfg
);
    import pbgr_pkg::*;

    pbgr_cfg_t cfg_reg;
    reg_idx_t  reg_idx;
    logic      wr_en;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.font_valid   <= 1'b0;
            cfg_reg.first_char   <= 8'd0;
            cfg_reg.glyph_height <= 6'd8;
            cfg_reg.row_pitch    <= 12'd640;
            cfg_reg.clip_left    <= 12'd0;
            cfg_reg.clip_top     <= 11'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FONT_VALID:   cfg_reg.font_valid   <= pwdata[0];
                REG_FIRST_CHAR:   cfg_reg.first_char   <= pwdata[7:0];
                REG_GLYPH_HEIGHT: cfg_reg.glyph_height <= pwdata[5:0];
                REG_ROW_PITCH:    cfg_reg.row_pitch    <= pwdata[11:0];
                REG_CLIP_LEFT:    cfg_reg.clip_left    <= pwdata[11:0];
                REG_CLIP_TOP:     cfg_reg.clip_top     <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FONT_VALID:   prdata = PDATA_W'(cfg_reg.font_valid);
            REG_FIRST_CHAR:   prdata = PDATA_W'(cfg_reg.first_char);
            REG_GLYPH_HEIGHT: prdata = PDATA_W'(cfg_reg.glyph_height);
            REG_ROW_PITCH:    prdata = PDATA_W'(cfg_reg.row_pitch);
            REG_CLIP_LEFT:    prdata = PDATA_W'(cfg_reg.clip_left);
            REG_CLIP_TOP:     prdata = PDATA_W'(cfg_reg.clip_top);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/proportional_bitmap_glyph_renderer_unit.sv =====
// Top level of the proportional bitmap glyph renderer: glyph table, font store, row sequencer.
//
//  channel  | ports             | moves
//  ---------+-------------------+---------------------------------------------
//  input    | s_valid/s_ready   | one load, begin or draw item (s_item)
//  result   | m_valid/m_ready   | one masked row write or error (m_item)
//  config   | psel..pready      | APB register writes and reads
//
// Load and begin items are handled on acceptance. A draw item passes through accept
// and glyph table read, row address multiply, row address add, then one font store
// read per row; an error gives one error result. The font store's single read
// port sets the row rate. Reset clears control state only; tables and store are
// undefined until written. A stalled result stage holds up row reads; the next
// item waits until all rows of the current draw have been read.
module proportional_bitmap_glyph_renderer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pbgr_pkg::pbgr_in_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pbgr_pkg::pbgr_out_t           m_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbgr_pkg::PADDR_W-1:0]  paddr,
    input  logic [pbgr_pkg::PDATA_W-1:0]  pwdata,
    output logic [pbgr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import pbgr_pkg::*;

    pbgr_cfg_t    cfg;

    glyph_entry_t glyph_mem [GLYPH_COUNT];
    logic [7:0]   font_mem  [FONT_BYTES];

    seq_state_t   state_reg, state_next;

    // sequencer registers
    status_t              err_reg;
    logic [15:0]          pen_reg;
    logic [10:0]          line_top_reg;
    logic [7:0]           colour_reg;
    glyph_entry_t         glyph_rdata_reg;
    logic [22:0]          prod_reg;
    logic [23:0]          row_addr_reg;
    logic [FONT_AW-1:0]   font_addr_reg;
    logic [ROW_W-1:0]     rows_left_reg;
    logic [7:0]           colmask_reg;
    logic [15:0]          new_pen_reg;

    // row stage between font read and result register
    logic                 s1_valid_reg;
    status_t              s1_status_reg;
    logic [23:0]          s1_addr_reg;
    logic [7:0]           s1_colmask_reg;
    logic [7:0]           s1_colour_reg;
    logic [15:0]          s1_pen_reg;
    logic                 s1_last_reg;
    logic [7:0]           font_rdata_reg;

    logic                 m_valid_reg;
    pbgr_out_t            m_item_reg;

    // combinational
    logic                 accept;
    logic                 out_free;
    logic                 s1_free;
    logic                 issue;
    logic [7:0]           glyph_diff;
    logic                 glyph_in_range;
    logic                 glyph_we;
    logic                 font_we;
    logic                 glyph_re;
    logic [3:0]           cols;
    logic [15:0]          colmask_wide;
    logic [6:0]           rows_count;
    logic                 blank;

    pbgr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready   = 1'b1;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;

    assign glyph_diff     = s_item.char_code - cfg.first_char;
    assign glyph_in_range = (s_item.char_code >= cfg.first_char) &&
                            ({1'b0, glyph_diff} < GLYPH_LIMIT);
    assign glyph_we = accept && (s_item.action == ACT_GLYPH) &&
                      ({1'b0, s_item.char_code} < GLYPH_LIMIT);
    assign font_we  = accept && (s_item.action == ACT_BYTE) &&
                      ({5'd0, s_item.byte_address} < FONT_LIMIT);
    assign glyph_re = accept && (s_item.action == ACT_DRAW);

    // column mask covers the first min(width, 8) pixels
    assign cols         = (glyph_rdata_reg.width < 8'd8) ? glyph_rdata_reg.width[3:0] : 4'd8;
    assign colmask_wide = 16'hFF00 >> cols;

    // row count: limited to the maximum height; zero height gives one blank row
    always_comb begin
        blank = 1'b0;
        if (cfg.glyph_height == 6'd0) begin
            rows_count = 7'd1;
            blank      = 1'b1;
        end else if ({1'b0, cfg.glyph_height} > HEIGHT_LIMIT) begin
            rows_count = HEIGHT_LIMIT;
        end else begin
            rows_count = {1'b0, cfg.glyph_height};
        end
    end

    // glyph table
    always_ff @(posedge aclk) begin
        if (glyph_we) begin
            glyph_mem[s_item.char_code[GLYPH_AW-1:0]] <= '{
                width:  s_item.glyph_width,
                offset: s_item.glyph_offset
            };
        end
        if (glyph_re) begin
            glyph_rdata_reg <= glyph_mem[glyph_diff[GLYPH_AW-1:0]];
        end
    end

    // font store
    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[FONT_AW'(s_item.byte_address)] <= s_item.byte_value;
        end
        if (issue) begin
            font_rdata_reg <= font_mem[font_addr_reg];
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept && s_item.action == ACT_DRAW) state_next = SEQ_LOOKUP;
            end
            SEQ_LOOKUP: begin
                state_next = (err_reg == STS_OK) ? SEQ_SETUP : SEQ_ERROR;
            end
            SEQ_SETUP: begin
                state_next = SEQ_ROWS;
            end
            SEQ_ROWS: begin
                if (issue && rows_left_reg == '0) state_next = SEQ_IDLE;
            end
            SEQ_ERROR: begin
                if (issue) state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:   s_ready = 1'b1;
            SEQ_LOOKUP: ;
            SEQ_SETUP:  ;
            SEQ_ROWS:   issue = s1_free;
            SEQ_ERROR:  issue = s1_free;
            default:    ;
        endcase
    end

    // pen, line top and colour
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg      <= 16'd0;
            line_top_reg <= 11'd0;
            colour_reg   <= 8'd0;
        end else if (accept && s_item.action == ACT_BEGIN) begin
            pen_reg      <= 16'({1'b0, s_item.start_x} + {1'b0, cfg.clip_left});
            line_top_reg <= s_item.start_y + cfg.clip_top;
            colour_reg   <= s_item.text_colour;
        end else if (state_reg == SEQ_ROWS && issue && rows_left_reg == '0) begin
            pen_reg      <= new_pen_reg;
        end
    end

    // per-character setup and row walk
    always_ff @(posedge aclk) begin
        if (accept && s_item.action == ACT_DRAW) begin
            if (!cfg.font_valid) begin
                err_reg <= STS_NO_FONT;
            end else if (!glyph_in_range) begin
                err_reg <= STS_BAD_GLYPH;
            end else begin
                err_reg <= STS_OK;
            end
        end
        if (state_reg == SEQ_LOOKUP) begin
            prod_reg      <= {12'd0, line_top_reg} * {11'd0, cfg.row_pitch};
            font_addr_reg <= FONT_AW'(glyph_rdata_reg.offset);
            rows_left_reg <= ROW_W'(rows_count - 7'd1);
            colmask_reg   <= blank ? 8'd0 : colmask_wide[7:0];
            new_pen_reg   <= pen_reg + {8'd0, glyph_rdata_reg.width};
        end
        if (state_reg == SEQ_SETUP) begin
            row_addr_reg <= {1'b0, prod_reg} + {8'd0, pen_reg};
        end
        if (state_reg == SEQ_ROWS && issue) begin
            row_addr_reg  <= row_addr_reg + {12'd0, cfg.row_pitch};
            font_addr_reg <= font_addr_reg + FONT_AW'(1);
            rows_left_reg <= rows_left_reg - ROW_W'(1);
        end
    end

    // row stage: waits with the font byte while the result register is full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (issue) begin
            s1_valid_reg <= 1'b1;
        end else if (out_free) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            if (state_reg == SEQ_ERROR) begin
                s1_status_reg  <= err_reg;
                s1_addr_reg    <= 24'd0;
                s1_colmask_reg <= 8'd0;
                s1_colour_reg  <= 8'd0;
                s1_pen_reg     <= pen_reg;
                s1_last_reg    <= 1'b1;
            end else begin
                s1_status_reg  <= STS_OK;
                s1_addr_reg    <= row_addr_reg;
                s1_colmask_reg <= colmask_reg;
                s1_colour_reg  <= colour_reg;
                s1_pen_reg     <= new_pen_reg;
                s1_last_reg    <= (rows_left_reg == '0);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && out_free) begin
            m_item_reg.status       <= s1_status_reg;
            m_item_reg.row_address  <= s1_addr_reg;
            m_item_reg.pixel_mask   <= font_rdata_reg & s1_colmask_reg;
            m_item_reg.pixel_colour <= s1_colour_reg;
            m_item_reg.pen_x        <= s1_pen_reg;
            m_item_reg.last         <= s1_last_reg;
        end
    end

endmodule

// ===== hw/rtl/pbgr_checker.sv =====
// Port-level checks for the glyph renderer, bound to its top level.
module pbgr_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input pbgr_pkg::pbgr_out_t  m_item
);
    import pbgr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != STS_OK |-> m_item.last)
        else $error("error result is not the last of its character");

    a_err_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != STS_OK |->
            m_item.pixel_mask == 8'd0 && m_item.row_address == 24'd0 &&
            m_item.pixel_colour == 8'd0)
        else $error("error result carries a row write");

    // a result that directly follows a non-last row has OK status and the same pen and colour
    a_rows_same_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last |=>
            !m_valid || (m_item.status == STS_OK &&
                         m_item.pen_x == $past(m_item.pen_x) &&
                         m_item.pixel_colour == $past(m_item.pixel_colour)))
        else $error("character rows broken up");

endmodule

bind proportional_bitmap_glyph_renderer_unit pbgr_checker u_pbgr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
